// ----- design/matrix_line_rotator_unit_assert.svh -----
// Assertion macros shared by the matrix line rotator RTL.
`ifndef MATRIX_LINE_ROTATOR_UNIT_ASSERT_SVH
`define MATRIX_LINE_ROTATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mlr_pkg.sv -----
// Package with sizes, codes and helpers of the matrix line rotator.
package mlr_pkg;

   localparam int MAX_DIM    = 32;
   localparam int ELEM_WIDTH = 32;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   localparam int OP_W     = 3;
   localparam int LINE_W   = 6;
   localparam int AMT_W    = 10;
   localparam int RADDR_W  = 5;
   localparam int CADDR_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int BIT_CNT_W = $clog2(AMT_W);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 3'd0,
      OP_READ      = 3'd1,
      OP_ROW_RIGHT = 3'd2,
      OP_ROW_LEFT  = 3'd3,
      OP_COL_DOWN  = 3'd4,
      OP_COL_UP    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_LINE = 2'd1,
      ST_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT = 2'd0,
      CSR_COL_COUNT = 2'd1
   } csr_index_type;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

   // Clamps a configured count into the range 1 to MAX_DIM.
   function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] count);
      logic [CNT_W-1:0] result;
      if (count == '0) begin
         result = CNT_W'(1);
      end else if (count > MAX_DIM) begin
         result = CNT_W'(MAX_DIM);
      end else begin
         result = CNT_W'(count);
      end
      return result;
   endfunction

   // Sign-extends or truncates a stored element to the result width.
   function automatic logic [VALUE_W-1:0] elem_to_value(input elem_type elem);
      logic signed [ELEM_WIDTH-1:0] selem;
      selem = signed'(elem);
      return VALUE_W'(selem);
   endfunction

endpackage

// ----- design/matrix_line_rotator_unit.sv -----
// Matrix line rotator: element load and read, circular row and column rotation.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall| operation, line_index, amount, addresses, value
//   rsp     | out       | rsp_valid/rsp_stall| read_value, status
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// A load, an erroneous request or an unknown operation gives its result in the cycle after
// the transfer; a read first passes through S_RDWAIT, where the registered memory word is
// taken. A rotation of a line of length L runs ten remainder steps, then copies the line
// into the line buffer and writes it back at the shifted positions. One request is in
// work at a time. Synchronous reset sets both counts to 32; the memories hold no reset
// value. A result waiting under rsp_stall holds off every request until it is transferred.
`include "matrix_line_rotator_unit_assert.svh"

module matrix_line_rotator_unit import mlr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_operation,
   input  logic [LINE_W-1:0]          req_line_index,
   input  logic [AMT_W-1:0]           req_amount,
   input  logic [RADDR_W-1:0]         req_row_addr,
   input  logic [CADDR_W-1:0]         req_col_addr,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDWAIT,
      S_MOD,
      S_LOAD,
      S_STORE
   } state_type;

   elem_type matrix_store [DEPTH];
   elem_type line_buffer [MAX_DIM];

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       row_count_ff, row_count_in;
   logic [CFG_W-1:0]       col_count_ff, col_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]       len_ff, len_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [IDX_W-1:0]       dst_ff, dst_in;
   logic [IDX_W-1:0]       line_ff, line_in;
   logic                   is_row_ff, is_row_in;
   logic                   forward_ff, forward_in;
   logic [AMT_W-1:0]       amt_ff, amt_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   wr_vld_ff, wr_vld_in;
   elem_type               mem_q_ff;
   elem_type               buf_q_ff;

   logic                   accept;
   logic                   rsp_set;
   logic [CNT_W-1:0]       rows_eff;
   logic [CNT_W-1:0]       cols_eff;
   logic                   addr_bad;
   logic [IDX_W-1:0]       line_req;
   logic [IDX_W-1:0]       cnt_idx;
   logic [ADDR_W-1:0]      elem_addr;
   logic [CNT_W:0]         rem_shift;
   logic [CNT_W-1:0]       rem_step;
   logic [CNT_W-1:0]       dst_start;
   logic [CNT_W-1:0]       dst_inc;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   elem_type               mem_wdata;
   logic [ADDR_W-1:0]      mem_raddr;
   logic                   buf_we;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = signed'(rsp_value_ff);
   assign rsp_status     = rsp_status_ff;

   assign rows_eff  = eff_count(row_count_ff);
   assign cols_eff  = eff_count(col_count_ff);
   assign addr_bad  = (req_row_addr >= rows_eff) || (req_col_addr >= cols_eff);
   assign line_req  = IDX_W'(req_line_index - LINE_W'(1));
   assign elem_addr = {IDX_W'(req_row_addr), IDX_W'(req_col_addr)};
   assign cnt_idx   = cnt_ff[IDX_W-1:0];

   assign rem_shift = {rem_ff, amt_ff[AMT_W-1]};
   assign rem_step  = (rem_shift >= {1'b0, len_ff}) ? CNT_W'(rem_shift - {1'b0, len_ff})
                                                    : CNT_W'(rem_shift);
   assign dst_start = (forward_ff || rem_step == '0) ? rem_step : CNT_W'(len_ff - rem_step);
   assign dst_inc   = CNT_W'(dst_ff) + CNT_W'(1);

   assign buf_we = rd_vld_ff;

   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      dst_in        = dst_ff;
      line_in       = line_ff;
      is_row_in     = is_row_ff;
      forward_in    = forward_ff;
      amt_in        = amt_ff;
      bit_cnt_in    = bit_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      wr_vld_in     = 1'b0;
      rsp_set       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = elem_addr;
      mem_wdata     = elem_type'(req_value);
      mem_raddr     = elem_addr;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               amt_in        = req_amount;
               rem_in        = '0;
               bit_cnt_in    = '0;
               line_in       = line_req;
               unique case (op_type'(req_operation)) inside
                  OP_LOAD, OP_READ: begin
                     if (addr_bad) begin
                        rsp_status_in = ST_BAD_ADDR;
                        rsp_set       = 1'b1;
                     end else if (op_type'(req_operation) == OP_LOAD) begin
                        mem_we  = 1'b1;
                        rsp_set = 1'b1;
                     end else begin
                        state_in = S_RDWAIT;
                     end
                  end
                  OP_ROW_RIGHT, OP_ROW_LEFT: begin
                     is_row_in  = 1'b1;
                     forward_in = (op_type'(req_operation) == OP_ROW_RIGHT);
                     len_in     = cols_eff;
                     if (req_line_index == '0 || req_line_index > rows_eff) begin
                        rsp_status_in = ST_BAD_LINE;
                        rsp_set       = 1'b1;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  OP_COL_DOWN, OP_COL_UP: begin
                     is_row_in  = 1'b0;
                     forward_in = (op_type'(req_operation) == OP_COL_DOWN);
                     len_in     = rows_eff;
                     if (req_line_index == '0 || req_line_index > cols_eff) begin
                        rsp_status_in = ST_BAD_LINE;
                        rsp_set       = 1'b1;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  default: begin
                     rsp_set = 1'b1;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_value_in  = elem_to_value(mem_q_ff);
            rsp_status_in = ST_OK;
            rsp_set       = 1'b1;
            state_in      = S_IDLE;
         end
         S_MOD: begin
            rem_in     = rem_step;
            amt_in     = amt_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(AMT_W - 1)) begin
               dst_in   = IDX_W'(dst_start);
               cnt_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            mem_raddr = is_row_ff ? {line_ff, cnt_idx} : {cnt_idx, line_ff};
            if (cnt_ff < len_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_idx;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in   = '0;
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            mem_waddr = is_row_ff ? {line_ff, dst_ff} : {dst_ff, line_ff};
            mem_wdata = buf_q_ff;
            mem_we    = wr_vld_ff;
            if (wr_vld_ff) begin
               dst_in = (dst_inc == len_ff) ? '0 : IDX_W'(dst_inc);
            end
            if (cnt_ff < len_ff) begin
               wr_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               rsp_set       = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= CFG_W'(MAX_DIM);
         col_count_ff <= CFG_W'(MAX_DIM);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         wr_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         wr_vld_ff    <= wr_vld_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      dst_ff        <= dst_in;
      line_ff       <= line_in;
      is_row_ff     <= is_row_in;
      forward_ff    <= forward_in;
      amt_ff        <= amt_in;
      bit_cnt_ff    <= bit_cnt_in;
      rd_idx_ff     <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_store[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= matrix_store[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         line_buffer[rd_idx_ff] <= mem_q_ff;
      end
      buf_q_ff <= line_buffer[cnt_idx];
   end

   `MLR_ASSERT_NOW(a_result_slot_free, rsp_set, !rsp_valid_ff || !rsp_stall,
      "A result was loaded over one that had not been transferred.")
   `MLR_ASSERT_NOW(a_rem_in_range, state_ff == S_MOD, rem_ff < len_ff,
      "The rotation remainder left the line length.")
   `MLR_ASSERT_NOW(a_dst_in_range, state_ff == S_STORE, dst_ff < len_ff && cnt_ff <= len_ff,
      "A write-back position left the line.")
   `MLR_ASSERT_NOW(a_copy_done, state_ff == S_STORE, !buf_we,
      "The line buffer was still being filled during write-back.")
   `MLR_ASSERT_NEXT(a_mod_to_load, state_ff == S_MOD && bit_cnt_ff == BIT_CNT_W'(AMT_W - 1),
      state_ff == S_LOAD && cnt_ff == '0,
      "The remainder steps did not hand over to the line copy.")

endmodule
